### design/virtio_pci_common_config_regs_assert.svh
`ifndef VIRTIO_PCI_COMMON_CONFIG_REGS_ASSERT_SVH
`define VIRTIO_PCI_COMMON_CONFIG_REGS_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define VPCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define VPCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/vpcc_pkg.sv
`timescale 1ns / 1ps

package vpcc_pkg;

	localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'h00;
	localparam logic [7:0] OFF_DEV_FEAT     = 8'h04;
	localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'h08;
	localparam logic [7:0] OFF_DRV_FEAT     = 8'h0C;
	localparam logic [7:0] OFF_NUM_QUEUES   = 8'h12;
	localparam logic [7:0] OFF_STATUS       = 8'h14;
	localparam logic [7:0] OFF_CFG_GEN      = 8'h15;
	localparam logic [7:0] OFF_Q_SELECT     = 8'h16;
	localparam logic [7:0] OFF_Q_SIZE       = 8'h18;
	localparam logic [7:0] OFF_Q_ENABLE     = 8'h1C;
	localparam logic [7:0] OFF_Q_NOTIFY_OFF = 8'h1E;
	localparam logic [7:0] OFF_Q_DESC_LO    = 8'h20;
	localparam logic [7:0] OFF_Q_DESC_HI    = 8'h24;
	localparam logic [7:0] OFF_Q_AVAIL_LO   = 8'h28;
	localparam logic [7:0] OFF_Q_AVAIL_HI   = 8'h2C;
	localparam logic [7:0] OFF_Q_USED_LO    = 8'h30;
	localparam logic [7:0] OFF_Q_USED_HI    = 8'h34;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_BAD  = 2'd3;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [1:0] CFG_DEV_FEATURES   = 2'd0;
	localparam logic [1:0] CFG_CONFIG_GEN     = 2'd1;
	localparam logic [1:0] CFG_OFFERED_QUEUES = 2'd2;
	localparam logic [1:0] CFG_DEFAULT_QSIZE  = 2'd3;

	localparam logic [63:0] RST_DEV_FEATURES  = 64'h0000_0001_0000_0000;
	localparam logic [4:0]  RST_OFFERED       = 5'd1;
	localparam logic [15:0] RST_DEFAULT_QSIZE = 16'd256;

	typedef struct packed {
		logic [63:0] dev_features;
		logic [7:0]  config_generation;
		logic [4:0]  offered_queues;
		logic [15:0] default_queue_size;
	} cfg_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] active;
		logic [15:0] pending;
		logic [31:0] desc_hi;
		logic [31:0] desc_lo;
		logic [31:0] avail_hi;
		logic [31:0] avail_lo;
		logic [31:0] used_hi;
		logic [31:0] used_lo;
	} qrow_t;

	typedef struct packed {
		logic [31:0] rd_value;
		logic        bad_size;
		logic        ring_setup;
		logic [3:0]  ring_queue;
		logic [15:0] ring_size;
		logic [63:0] desc_address;
		logic [63:0] avail_address;
		logic [63:0] used_address;
		logic        device_reset;
		logic        features_update;
		logic [63:0] driver_features_out;
	} res_t;

endpackage

### design/vpcc_if.sv
`timescale 1ns / 1ps

interface vpcc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  offset;
	logic [1:0]  access_size;
	logic [31:0] wr_value;

	modport source (output valid, cmd, offset, access_size, wr_value, input ready);
	modport sink (input valid, cmd, offset, access_size, wr_value, output ready);
endinterface

interface vpcc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] rd_value;
	logic        bad_size;
	logic        ring_setup;
	logic [3:0]  ring_queue;
	logic [15:0] ring_size;
	logic [63:0] desc_address;
	logic [63:0] avail_address;
	logic [63:0] used_address;
	logic        device_reset;
	logic        features_update;
	logic [63:0] driver_features_out;

	modport source (output valid, rd_value, bad_size, ring_setup, ring_queue, ring_size,
		desc_address, avail_address, used_address, device_reset, features_update,
		driver_features_out, input ready);
	modport sink (input valid, rd_value, bad_size, ring_setup, ring_queue, ring_size,
		desc_address, avail_address, used_address, device_reset, features_update,
		driver_features_out, output ready);
endinterface

### design/virtio_pci_common_config_regs.sv
`timescale 1ns / 1ps

// Common-configuration register block for a modern VirtIO PCI function. Accesses arrive one at
// a time on in_ch and each gives exactly one beat on out_ch. Per-queue state sits in one
// synchronous memory row per queue (QUEUE_COUNT rows). The accept cycle reads the selected
// queue's row; the next cycle decodes, writes the row back where the access changes it and
// loads the output register if it is free. A num-queues read scans every row through the
// memory read port. A zero status write runs a clearing pass over all QUEUE_COUNT rows before
// its beat is offered; the same pass follows reset, so in_ch.ready first rises once that pass
// is complete after arst_n is released. The next access is taken once the previous beat is in
// the output register, even while it waits on out_ch.

`include "virtio_pci_common_config_regs_assert.svh"

module virtio_pci_common_config_regs import vpcc_pkg::*; #(
	parameter int QUEUE_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	vpcc_in_if.sink     in_ch,
	vpcc_out_if.source  out_ch
);

	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int CW = $clog2(QUEUE_COUNT + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	cfg_t cfg;

	logic [2:0]    state_q;
	logic [QW-1:0] clr_idx_q;
	logic          clr_resp_q;
	logic [4:0]    sw_offered_q;
	logic [15:0]   sw_default_q;

	logic [31:0]   dev_sel_q;
	logic [31:0]   drv_sel_q;
	logic [31:0]   drv_words_q [2];
	logic [7:0]    status_q;
	logic [QW-1:0] sel_q_q;

	logic [31:0]   dev_sel_d;
	logic [31:0]   drv_sel_d;
	logic [31:0]   drv_words_d [2];
	logic [7:0]    status_d;
	logic [QW-1:0] sel_d;
	logic          zero_status;
	logic          scan_start;

	logic          cmd_s1;
	logic [7:0]    offset_s1;
	logic [1:0]    size_s1;
	logic [31:0]   data_s1;

	logic [CW-1:0] scan_idx_q;
	logic          scan_vld_s1;
	logic [QW-1:0] scan_tag_s1;
	logic [CW-1:0] scan_cnt_q;
	logic          scan_issue;

	logic          mem_we;
	logic [QW-1:0] mem_waddr;
	qrow_t         mem_wdata;
	logic          mem_re;
	logic [QW-1:0] mem_raddr;
	qrow_t         rd_row;
	qrow_t         row_w;
	qrow_t         clr_row;
	logic          q_wr;

	logic [31:0]   wdata;
	res_t          res_d;
	res_t          res_q;
	res_t          out_q;
	logic          out_valid_q;
	logic          out_free;
	logic          out_load;
	logic          accept;

	logic          wr_state;
	logic          ring_beat;
	logic          beat_clean;

	vpcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vpcc_qmem #(
		.DEPTH (QUEUE_COUNT),
		.AW    (QW)
	) u_qmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_row)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign scan_issue  = (state_q == ST_SCAN) && (scan_idx_q < CW'(QUEUE_COUNT));
	assign out_load    = ((state_q == ST_EXEC) && !scan_start && !zero_status && out_free) ||
		((state_q == ST_DONE) && out_free);

	assign mem_re    = accept || scan_issue;
	assign mem_raddr = (state_q == ST_SCAN) ? scan_idx_q[QW-1:0] : sel_q_q;

	always_comb begin
		clr_row = '0;
		if (32'(clr_idx_q) < 32'(sw_offered_q)) begin
			clr_row.active = sw_default_q;
		end
	end

	assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_EXEC) && q_wr);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_idx_q : sel_q_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? clr_row : row_w;

	always_comb begin
		wdata = data_s1;
		case (size_s1)
			SZ_BYTE: wdata = {24'd0, data_s1[7:0]};
			SZ_HALF: wdata = {16'd0, data_s1[15:0]};
			default: ;
		endcase
	end

	always_comb begin
		row_w          = rd_row;
		res_d          = '0;
		q_wr           = 1'b0;
		dev_sel_d      = dev_sel_q;
		drv_sel_d      = drv_sel_q;
		drv_words_d[0] = drv_words_q[0];
		drv_words_d[1] = drv_words_q[1];
		status_d       = status_q;
		sel_d          = sel_q_q;
		zero_status    = 1'b0;
		scan_start     = 1'b0;
		if (cmd_s1 == CMD_READ) begin
			unique case (offset_s1) inside
				OFF_DEV_FEAT_SEL: res_d.rd_value = dev_sel_q;
				OFF_DEV_FEAT: begin
					if (dev_sel_q == 32'd0) begin
						res_d.rd_value = cfg.dev_features[31:0];
					end else if (dev_sel_q == 32'd1) begin
						res_d.rd_value = cfg.dev_features[63:32];
					end
				end
				OFF_DRV_FEAT_SEL: res_d.rd_value = drv_sel_q;
				OFF_DRV_FEAT: begin
					if (drv_sel_q <= 32'd1) begin
						res_d.rd_value = drv_words_q[drv_sel_q[0]];
					end
				end
				OFF_NUM_QUEUES: scan_start = 1'b1;
				OFF_STATUS: res_d.rd_value = {24'd0, status_q};
				OFF_CFG_GEN: res_d.rd_value = {24'd0, cfg.config_generation};
				OFF_Q_SELECT, OFF_Q_NOTIFY_OFF: res_d.rd_value = 32'(sel_q_q);
				OFF_Q_SIZE: res_d.rd_value = {16'd0, rd_row.active};
				OFF_Q_ENABLE: res_d.rd_value = {31'd0, rd_row.enabled};
				OFF_Q_DESC_LO: res_d.rd_value = rd_row.desc_lo;
				OFF_Q_DESC_HI: res_d.rd_value = rd_row.desc_hi;
				OFF_Q_AVAIL_LO: res_d.rd_value = rd_row.avail_lo;
				OFF_Q_AVAIL_HI: res_d.rd_value = rd_row.avail_hi;
				OFF_Q_USED_LO: res_d.rd_value = rd_row.used_lo;
				OFF_Q_USED_HI: res_d.rd_value = rd_row.used_hi;
				default: ;
			endcase
		end else if (size_s1 == SZ_BAD) begin
			res_d.bad_size = 1'b1;
		end else begin
			unique case (offset_s1)
				OFF_DEV_FEAT_SEL: dev_sel_d = wdata;
				OFF_DRV_FEAT_SEL: drv_sel_d = wdata;
				OFF_DRV_FEAT: begin
					if (drv_sel_q <= 32'd1) begin
						drv_words_d[drv_sel_q[0]]  = wdata;
						res_d.features_update     = 1'b1;
						res_d.driver_features_out = {drv_words_d[1], drv_words_d[0]};
					end
				end
				OFF_STATUS: begin
					status_d = wdata[7:0];
					if (wdata[7:0] == 8'd0) begin
						zero_status        = 1'b1;
						res_d.device_reset = 1'b1;
					end
				end
				OFF_Q_SELECT: begin
					if (wdata < 32'(QUEUE_COUNT)) begin
						sel_d = wdata[QW-1:0];
					end
				end
				OFF_Q_SIZE: begin
					row_w.pending = wdata[15:0];
					q_wr          = 1'b1;
				end
				OFF_Q_ENABLE: begin
					row_w.active        = rd_row.pending;
					row_w.enabled       = 1'b1;
					q_wr                = 1'b1;
					res_d.ring_setup    = 1'b1;
					res_d.ring_queue    = 4'(sel_q_q);
					res_d.ring_size     = rd_row.pending;
					res_d.desc_address  = {rd_row.desc_hi, rd_row.desc_lo};
					res_d.avail_address = {rd_row.avail_hi, rd_row.avail_lo};
					res_d.used_address  = {rd_row.used_hi, rd_row.used_lo};
				end
				OFF_Q_DESC_LO: begin
					row_w.desc_lo = wdata;
					q_wr          = 1'b1;
				end
				OFF_Q_DESC_HI: begin
					row_w.desc_hi = wdata;
					q_wr          = 1'b1;
				end
				OFF_Q_AVAIL_LO: begin
					row_w.avail_lo = wdata;
					q_wr           = 1'b1;
				end
				OFF_Q_AVAIL_HI: begin
					row_w.avail_hi = wdata;
					q_wr           = 1'b1;
				end
				OFF_Q_USED_LO: begin
					row_w.used_lo = wdata;
					q_wr          = 1'b1;
				end
				OFF_Q_USED_HI: begin
					row_w.used_hi = wdata;
					q_wr          = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_idx_q      <= '0;
			clr_resp_q     <= 1'b0;
			sw_offered_q   <= RST_OFFERED;
			sw_default_q   <= RST_DEFAULT_QSIZE;
			dev_sel_q      <= '0;
			drv_sel_q      <= '0;
			drv_words_q[0] <= '0;
			drv_words_q[1] <= '0;
			status_q       <= '0;
			sel_q_q        <= '0;
			scan_idx_q     <= '0;
			scan_vld_s1    <= 1'b0;
			scan_cnt_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					dev_sel_q      <= dev_sel_d;
					drv_sel_q      <= drv_sel_d;
					drv_words_q[0] <= drv_words_d[0];
					drv_words_q[1] <= drv_words_d[1];
					status_q       <= status_d;
					sel_q_q        <= sel_d;
					if (scan_start) begin
						scan_idx_q  <= '0;
						scan_vld_s1 <= 1'b0;
						scan_cnt_q  <= '0;
						state_q     <= ST_SCAN;
					end else if (zero_status) begin
						clr_idx_q    <= '0;
						clr_resp_q   <= 1'b1;
						sw_offered_q <= cfg.offered_queues;
						sw_default_q <= cfg.default_queue_size;
						state_q      <= ST_CLEAR;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					scan_vld_s1 <= scan_issue;
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (scan_vld_s1 && (rd_row.active != 16'd0)) begin
						scan_cnt_q <= CW'(scan_tag_s1) + 1'b1;
					end
					if (!scan_issue && !scan_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (clr_idx_q == QW'(QUEUE_COUNT - 1)) begin
						clr_idx_q  <= '0;
						clr_resp_q <= 1'b0;
						state_q    <= clr_resp_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= in_ch.cmd;
			offset_s1 <= in_ch.offset;
			size_s1   <= in_ch.access_size;
			data_s1   <= in_ch.wr_value;
		end
		if (scan_issue) begin
			scan_tag_s1 <= scan_idx_q[QW-1:0];
		end
		if (state_q == ST_EXEC) begin
			res_q <= res_d;
			if (out_free) begin
				out_q <= res_d;
			end
		end
		if ((state_q == ST_SCAN) && !scan_issue && !scan_vld_s1) begin
			res_q.rd_value <= 32'(scan_cnt_q);
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.rd_value            = out_q.rd_value;
	assign out_ch.bad_size            = out_q.bad_size;
	assign out_ch.ring_setup          = out_q.ring_setup;
	assign out_ch.ring_queue          = out_q.ring_queue;
	assign out_ch.ring_size           = out_q.ring_size;
	assign out_ch.desc_address        = out_q.desc_address;
	assign out_ch.avail_address       = out_q.avail_address;
	assign out_ch.used_address        = out_q.used_address;
	assign out_ch.device_reset        = out_q.device_reset;
	assign out_ch.features_update     = out_q.features_update;
	assign out_ch.driver_features_out = out_q.driver_features_out;

	assign wr_state   = (state_q == ST_EXEC) || (state_q == ST_CLEAR);
	assign ring_beat  = out_ch.valid && out_ch.ring_setup;
	assign beat_clean = (out_ch.rd_value == 32'd0) && !out_ch.bad_size && !out_ch.device_reset;

	`VPCC_ASSERT_NXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC, "beat not decoded")
	`VPCC_ASSERT_IMP(a_mem_we_state, clk, arst_n, mem_we, wr_state, "stray row write")
	`VPCC_ASSERT_IMP(a_sel_range, clk, arst_n, 1'b1, 32'(sel_q_q) < 32'(QUEUE_COUNT), "bad select")
	`VPCC_ASSERT_IMP(a_ring_excl, clk, arst_n, ring_beat, beat_clean, "ring set-up beat mixed")

endmodule

### design/vpcc_cfg.sv
`timescale 1ns / 1ps

module vpcc_cfg import vpcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_features       <= RST_DEV_FEATURES;
			cfg_q.config_generation  <= 8'd0;
			cfg_q.offered_queues     <= RST_OFFERED;
			cfg_q.default_queue_size <= RST_DEFAULT_QSIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEV_FEATURES:   cfg_q.dev_features       <= cfg_data;
				CFG_CONFIG_GEN:     cfg_q.config_generation  <= cfg_data[7:0];
				CFG_OFFERED_QUEUES: cfg_q.offered_queues     <= cfg_data[4:0];
				CFG_DEFAULT_QSIZE:  cfg_q.default_queue_size <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/vpcc_qmem.sv
`timescale 1ns / 1ps

module vpcc_qmem import vpcc_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  qrow_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output qrow_t         rdata
);

	qrow_t mem [DEPTH];
	qrow_t rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule
